// ===== rtl/core/ddo_pkg.sv =====
`default_nettype none
package ddo_pkg;

   localparam int COUNT_BITS     = 16;
   localparam int CORDIC_DEF     = 24;
   localparam int TICK_W         = 24;
   localparam int CSR_IDX_W      = 2;
   localparam int ACC_W          = 48;
   localparam int HEAD_W         = 40;
   localparam int OUT_W          = 32;
   localparam int MUL_A_W        = 26;
   localparam int MUL_B_W        = 28;
   localparam int MUL_P_W        = MUL_A_W + MUL_B_W;
   localparam int ANG_W          = 28;
   localparam int RED_STEPS      = 13;

   localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 28'sd105414357;
   localparam logic signed [ANG_W-1:0] ANG_PI      = 28'sd52707179;
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 28'sd26353589;

   localparam logic [TICK_W-1:0] RIGHT_TICK_RESET = 24'd452004;
   localparam logic [TICK_W-1:0] LEFT_TICK_RESET  = 24'd452004;
   localparam logic [TICK_W-1:0] INV_SEP_RESET    = 24'd256000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RIGHT_TICK = 2'd0,
      CSR_LEFT_TICK  = 2'd1,
      CSR_INV_SEP    = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_UPDATE  = 1'b0,
      OP_CAPTURE = 1'b1
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MUL_R, ST_MUL_L, ST_ACC_L, ST_HLO, ST_HHI, ST_HACC,
      ST_RED, ST_FOLD, ST_CORD, ST_FIN, ST_XLO, ST_XHI, ST_XACC,
      ST_YHI, ST_YACC, ST_DONE
   } state_type;

   // Rounded arctangent of 2^-i, 2^-24 rad.
   function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] i);
      logic signed [ANG_W-1:0] r;
      case (i)
         5'd0:  r = 28'sd13176795;
         5'd1:  r = 28'sd7778716;
         5'd2:  r = 28'sd4110060;
         5'd3:  r = 28'sd2086331;
         5'd4:  r = 28'sd1047214;
         5'd5:  r = 28'sd524117;
         5'd6:  r = 28'sd262123;
         5'd7:  r = 28'sd131069;
         5'd8:  r = 28'sd65536;
         5'd9:  r = 28'sd32768;
         5'd10: r = 28'sd16384;
         5'd11: r = 28'sd8192;
         5'd12: r = 28'sd4096;
         5'd13: r = 28'sd2048;
         5'd14: r = 28'sd1024;
         5'd15: r = 28'sd512;
         5'd16: r = 28'sd256;
         5'd17: r = 28'sd128;
         5'd18: r = 28'sd64;
         5'd19: r = 28'sd32;
         5'd20: r = 28'sd16;
         5'd21: r = 28'sd8;
         5'd22: r = 28'sd4;
         5'd23: r = 28'sd2;
         5'd24: r = 28'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ddo_ifs.sv =====
`default_nettype none
interface ddo_req_if import ddo_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  op;
   logic [COUNT_BITS-1:0] left_count;
   logic [COUNT_BITS-1:0] right_count;
   modport source (output valid, op, left_count, right_count, input ready);
   modport sink   (input valid, op, left_count, right_count, output ready);
endinterface

interface ddo_rsp_if import ddo_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] pos_x;
   logic signed [OUT_W-1:0] pos_y;
   logic signed [OUT_W-1:0] heading;
   logic signed [OUT_W-1:0] left_travel;
   logic signed [OUT_W-1:0] right_travel;
   modport source (output valid, pos_x, pos_y, heading, left_travel, right_travel,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, heading, left_travel, right_travel,
                   output ready);
endinterface

interface ddo_csr_if import ddo_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [TICK_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/diff_drive_odometry_top.sv =====
`default_nettype none
// Differential-drive wheel odometry.
// req_if carries one beat per control tick: op (update or capture) and the raw
// left/right encoder counts. rsp_if returns one beat per request with the
// pose (pos_x, pos_y, heading) and wheel travels, all signed 2^-16 units.
// csr_if writes the tick lengths and reciprocal wheel separation; it is always
// ready and must be used only while the block is idle.
// A request is taken only in idle. An update runs a sequencer over one shared
// 26x28 multiplier (tick scaling, heading and position steps in two partial
// products each), a 13-step restoring reduction of the heading modulo 2*pi and
// CORDIC_STAGES CORDIC iterations, then loads the result beat. A capture beat
// returns zeros. The next request is taken the cycle after the result is
// loaded, even if rsp_if is stalled; a stalled result holds in the output
// register and a further result waits in its final state.
// Synchronous reset restores the register defaults and zeroes counts and pose.
module diff_drive_odometry_top import ddo_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_DEF
) (
   input wire logic clock,
   input wire logic reset,
   ddo_req_if.sink   req_if,
   ddo_rsp_if.source rsp_if,
   ddo_csr_if.sink   csr_if
);
   localparam int IW = $clog2(CORDIC_STAGES);
   localparam logic [IW-1:0] I_LAST = IW'(CORDIC_STAGES - 1);
   localparam int WIDE_W = 80;
   localparam int SPLIT  = 25;
   localparam int CH_W   = 50;
   localparam int V_W    = CH_W + 1;
   localparam int SUM_W  = 57;
   localparam int INC_W  = 56;
   localparam int CXY_W  = 34;
   localparam int REM_W  = HEAD_W + 1;
   localparam int DEL_W  = COUNT_BITS + 1;

   localparam logic signed [CXY_W-1:0] CORDIC_GAIN = 34'sd652032874;

   state_type state_ff, state_in;
   logic [COUNT_BITS-1:0] lcnt_ff, lcnt_in, rcnt_ff, rcnt_in;
   logic [TICK_W-1:0] tick_r_ff, tick_r_in, tick_l_ff, tick_l_in, inv_ff, inv_in;
   logic signed [ACC_W-1:0] lacc_ff, lacc_in, racc_ff, racc_in;
   logic signed [ACC_W-1:0] xacc_ff, xacc_in, yacc_ff, yacc_in;
   logic signed [HEAD_W-1:0] hacc_ff, hacc_in;
   logic signed [DEL_W-1:0] dl_ff, dl_in, dr_ff, dr_in;
   logic signed [CH_W-1:0] chl_ff, chl_in, chr_ff, chr_in;
   logic signed [WIDE_W-1:0] lo_ff, lo_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic hneg_ff, hneg_in, fneg_ff, fneg_in;
   logic [3:0] k_ff, k_in;
   logic signed [ANG_W-1:0] ang_ff, ang_in;
   logic signed [CXY_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [IW-1:0] i_ff, i_in;
   logic signed [MUL_B_W-1:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [OUT_W-1:0] ox_ff, ox_in, oy_ff, oy_in, oh_ff, oh_in;
   logic signed [OUT_W-1:0] ol_ff, ol_in, or_ff, or_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;

   ddo_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p_ff(mul_p));

   function automatic logic signed [ACC_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = (SUM_W'(1) <<< (ACC_W - 1)) - SUM_W'(1);
      lo = -hi - SUM_W'(1);
      if (v > hi) return ACC_W'(hi);
      if (v < lo) return ACC_W'(lo);
      return ACC_W'(v);
   endfunction

   function automatic logic signed [HEAD_W-1:0] sat40(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = (SUM_W'(1) <<< (HEAD_W - 1)) - SUM_W'(1);
      lo = -hi - SUM_W'(1);
      if (v > hi) return HEAD_W'(hi);
      if (v < lo) return HEAD_W'(lo);
      return HEAD_W'(v);
   endfunction

   // Fold a counter delta into -(half-1)..half.
   function automatic logic signed [DEL_W-1:0] fold(input logic [COUNT_BITS-1:0] now,
                                                    input logic [COUNT_BITS-1:0] last);
      logic [COUNT_BITS-1:0] m;
      logic [DEL_W-1:0]      half;
      m = now - last;
      half = DEL_W'(1) << (COUNT_BITS - 1);
      if (DEL_W'(m) > half) return $signed(DEL_W'(m) - (half << 1));
      return $signed(DEL_W'(m));
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lcnt_ff      <= '0;
         rcnt_ff      <= '0;
         tick_r_ff    <= RIGHT_TICK_RESET;
         tick_l_ff    <= LEFT_TICK_RESET;
         inv_ff       <= INV_SEP_RESET;
         lacc_ff      <= '0;
         racc_ff      <= '0;
         xacc_ff      <= '0;
         yacc_ff      <= '0;
         hacc_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lcnt_ff      <= lcnt_in;
         rcnt_ff      <= rcnt_in;
         tick_r_ff    <= tick_r_in;
         tick_l_ff    <= tick_l_in;
         inv_ff       <= inv_in;
         lacc_ff      <= lacc_in;
         racc_ff      <= racc_in;
         xacc_ff      <= xacc_in;
         yacc_ff      <= yacc_in;
         hacc_ff      <= hacc_in;
      end
      // Working payload, no reset.
      dl_ff   <= dl_in;
      dr_ff   <= dr_in;
      chl_ff  <= chl_in;
      chr_ff  <= chr_in;
      lo_ff   <= lo_in;
      rem_ff  <= rem_in;
      hneg_ff <= hneg_in;
      fneg_ff <= fneg_in;
      k_ff    <= k_in;
      ang_ff  <= ang_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      i_ff    <= i_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
      ox_ff   <= ox_in;
      oy_ff   <= oy_in;
      oh_ff   <= oh_in;
      ol_ff   <= ol_in;
      or_ff   <= or_in;
   end

   always_comb begin
      logic signed [V_W-1:0]    diff;
      logic signed [V_W-1:0]    mean;
      logic signed [WIDE_W-1:0] wide;
      logic signed [INC_W-1:0]  inc;
      logic signed [ACC_W-1:0]  nacc;
      logic signed [HEAD_W-1:0] nhead;
      logic signed [REM_W-1:0]  hs;
      logic [REM_W-1:0]         tp;
      logic signed [ANG_W-1:0]  r;
      logic signed [CXY_W-1:0]  sx;
      logic signed [CXY_W-1:0]  sy;
      logic signed [CXY_W-1:0]  fx;
      logic signed [CXY_W-1:0]  fy;

      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      lcnt_in = lcnt_ff;   rcnt_in = rcnt_ff;
      tick_r_in = tick_r_ff; tick_l_in = tick_l_ff; inv_in = inv_ff;
      lacc_in = lacc_ff;   racc_in = racc_ff;
      xacc_in = xacc_ff;   yacc_in = yacc_ff;   hacc_in = hacc_ff;
      dl_in = dl_ff;       dr_in = dr_ff;
      chl_in = chl_ff;     chr_in = chr_ff;
      lo_in = lo_ff;       rem_in = rem_ff;
      hneg_in = hneg_ff;   fneg_in = fneg_ff;
      k_in = k_ff;         ang_in = ang_ff;
      cx_in = cx_ff;       cy_in = cy_ff;   i_in = i_ff;
      cos_in = cos_ff;     sin_in = sin_ff;
      ox_in = ox_ff; oy_in = oy_ff; oh_in = oh_ff; ol_in = ol_ff; or_in = or_ff;
      mul_a = '0;
      mul_b = '0;

      diff = V_W'(chr_ff) - V_W'(chl_ff);
      mean = (V_W'(chr_ff) + V_W'(chl_ff)) >>> 1;
      // High partial product joined to the held low one, then floor by 2^24.
      wide = (WIDE_W'(mul_p) <<< SPLIT) + lo_ff;
      inc  = INC_W'(wide >>> 24);
      nacc = '0;
      nhead = '0;
      hs = '0;
      tp = REM_W'(ANG_TWO_PI) << k_ff;
      r = '0;
      sx = cx_ff >>> i_ff;
      sy = cy_ff >>> i_ff;
      fx = '0;
      fy = '0;

      // Drop the result beat once taken.
      if (rsp_valid_ff && rsp_if.ready) rsp_valid_in = 1'b0;

      // Register writes; an unknown index is ignored.
      if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_RIGHT_TICK: tick_r_in = csr_if.data;
            CSR_LEFT_TICK:  tick_l_in = csr_if.data;
            CSR_INV_SEP:    inv_in    = csr_if.data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               lcnt_in = req_if.left_count;
               rcnt_in = req_if.right_count;
               if (op_type'(req_if.op) == OP_CAPTURE) begin
                  lacc_in = '0; racc_in = '0;
                  xacc_in = '0; yacc_in = '0; hacc_in = '0;
                  state_in = ST_DONE;
               end else begin
                  dl_in = fold(req_if.left_count, lcnt_ff);
                  dr_in = fold(req_if.right_count, rcnt_ff);
                  state_in = ST_MUL_R;
               end
            end
         end
         ST_MUL_R: begin
            mul_a = MUL_A_W'(dr_ff);
            mul_b = $signed(MUL_B_W'(tick_r_ff));
            state_in = ST_MUL_L;
         end
         ST_MUL_L: begin
            // Keep the change the saturated accumulator really made.
            nacc = sat48(SUM_W'(racc_ff) + SUM_W'(mul_p));
            chr_in = CH_W'(SUM_W'(nacc) - SUM_W'(racc_ff));
            racc_in = nacc;
            mul_a = MUL_A_W'(dl_ff);
            mul_b = $signed(MUL_B_W'(tick_l_ff));
            state_in = ST_ACC_L;
         end
         ST_ACC_L: begin
            nacc = sat48(SUM_W'(lacc_ff) + SUM_W'(mul_p));
            chl_in = CH_W'(SUM_W'(nacc) - SUM_W'(lacc_ff));
            lacc_in = nacc;
            state_in = ST_HLO;
         end
         ST_HLO: begin
            mul_a = $signed({1'b0, diff[SPLIT-1:0]});
            mul_b = $signed(MUL_B_W'(inv_ff));
            state_in = ST_HHI;
         end
         ST_HHI: begin
            lo_in = WIDE_W'(mul_p);
            mul_a = MUL_A_W'(diff >>> SPLIT);
            mul_b = $signed(MUL_B_W'(inv_ff));
            state_in = ST_HACC;
         end
         ST_HACC: begin
            nhead = sat40(SUM_W'(hacc_ff) + SUM_W'(inc));
            hacc_in = nhead;
            hs = REM_W'(nhead);
            hneg_in = hs[REM_W-1];
            rem_in = hs[REM_W-1] ? REM_W'(-hs) : REM_W'(hs);
            k_in = 4'(RED_STEPS - 1);
            state_in = ST_RED;
         end
         ST_RED: begin
            // Restoring reduction of |heading| modulo 2*pi, one quotient bit a cycle.
            if (rem_ff >= tp) rem_in = rem_ff - tp;
            k_in = k_ff - 4'd1;
            if (k_ff == 4'd0) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            r = $signed(ANG_W'(rem_ff));
            if (hneg_ff) r = -r;
            if (r > ANG_PI) r = r - ANG_TWO_PI;
            if (r < -ANG_PI) r = r + ANG_TWO_PI;
            fneg_in = 1'b0;
            if (r > ANG_HALF_PI) begin
               r = r - ANG_PI;
               fneg_in = 1'b1;
            end else if (r < -ANG_HALF_PI) begin
               r = r + ANG_PI;
               fneg_in = 1'b1;
            end
            ang_in = r;
            cx_in = CORDIC_GAIN;
            cy_in = '0;
            i_in = '0;
            state_in = ST_CORD;
         end
         ST_CORD: begin
            if (ang_ff >= 0) begin
               cx_in = cx_ff - sy;
               cy_in = cy_ff + sx;
               ang_in = ang_ff - atan_lut(5'(i_ff));
            end else begin
               cx_in = cx_ff + sy;
               cy_in = cy_ff - sx;
               ang_in = ang_ff + atan_lut(5'(i_ff));
            end
            i_in = i_ff + IW'(1);
            if (i_ff == I_LAST) state_in = ST_FIN;
         end
         ST_FIN: begin
            fx = fneg_ff ? -cx_ff : cx_ff;
            fy = fneg_ff ? -cy_ff : cy_ff;
            cos_in = MUL_B_W'(fx >>> 6);
            sin_in = MUL_B_W'(fy >>> 6);
            state_in = ST_XLO;
         end
         ST_XLO: begin
            mul_a = $signed({1'b0, mean[SPLIT-1:0]});
            mul_b = cos_ff;
            state_in = ST_XHI;
         end
         ST_XHI: begin
            lo_in = WIDE_W'(mul_p);
            mul_a = MUL_A_W'(mean >>> SPLIT);
            mul_b = cos_ff;
            state_in = ST_XACC;
         end
         ST_XACC: begin
            xacc_in = sat48(SUM_W'(xacc_ff) + SUM_W'(inc));
            mul_a = $signed({1'b0, mean[SPLIT-1:0]});
            mul_b = sin_ff;
            state_in = ST_YHI;
         end
         ST_YHI: begin
            lo_in = WIDE_W'(mul_p);
            mul_a = MUL_A_W'(mean >>> SPLIT);
            mul_b = sin_ff;
            state_in = ST_YACC;
         end
         ST_YACC: begin
            yacc_in = sat48(SUM_W'(yacc_ff) + SUM_W'(inc));
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold here while an earlier beat still stalls the output register.
            if (!rsp_valid_ff || rsp_if.ready) begin
               ox_in = xacc_ff[ACC_W-1 -: OUT_W];
               oy_in = yacc_ff[ACC_W-1 -: OUT_W];
               oh_in = hacc_ff[HEAD_W-1 -: OUT_W];
               ol_in = lacc_ff[ACC_W-1 -: OUT_W];
               or_in = racc_ff[ACC_W-1 -: OUT_W];
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign csr_if.ready        = 1'b1;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.pos_x        = ox_ff;
   assign rsp_if.pos_y        = oy_ff;
   assign rsp_if.heading      = oh_ff;
   assign rsp_if.left_travel  = ol_ff;
   assign rsp_if.right_travel = or_ff;

endmodule
`default_nettype wire

// ===== rtl/core/ddo_mul.sv =====
`default_nettype none
// Shared signed multiplier, product registered.
module ddo_mul import ddo_pkg::*; (
   input  wire logic                      clock,
   input  wire logic signed [MUL_A_W-1:0] a,
   input  wire logic signed [MUL_B_W-1:0] b,
   output logic signed [MUL_P_W-1:0]      p_ff
);
   always_ff @(posedge clock) begin
      p_ff <= MUL_P_W'(a * b);
   end
endmodule
`default_nettype wire
